// File: hw/rtl/mfgp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfgp_pkg
// Shared types, command codes and the 6x8 font table for the glyph plotter.
// ----------------------------------------------------------------------------
package mfgp_pkg;

   localparam int DISPLAY_WIDTH_DEF  = 128;
   localparam int DISPLAY_HEIGHT_DEF = 64;

   localparam logic [1:0] OP_SET_PIXEL  = 2'd0;
   localparam logic [1:0] OP_DRAW_GLYPH = 2'd1;
   localparam logic [1:0] OP_CLEAR      = 2'd2;
   localparam logic [1:0] OP_READ_BYTE  = 2'd3;

   localparam int         GLYPH_COUNT      = 52;
   localparam logic [2:0] GLYPH_LAST_COL   = 3'd5;
   localparam logic [5:0] GLYPH_DIGIT_BASE = 6'd16;
   localparam logic [5:0] GLYPH_ALPHA_BASE = 6'd26;

   // latched command word
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic       pixel_on;
      logic [5:0] glyph;
   } cmd_type;

   // one byte update: which bits to touch and their new values
   typedef struct packed {
      logic [7:0] mask;
      logic [7:0] data;
   } byte_plan_type;

   // column n of a glyph sits in bits [8n+7:8n]; bit r is row r
   localparam logic [47:0] GLYPH_ROM [GLYPH_COUNT] = '{
      48'h00_00_00_00_00_00, 48'h00_00_00_5F_00_00, 48'h00_00_07_00_07_00,
      48'h00_14_7F_14_7F_14, 48'h00_12_2A_7F_2A_24, 48'h00_62_64_08_13_23,
      48'h00_50_22_55_49_36, 48'h00_00_00_03_05_00, 48'h00_00_41_22_1C_00,
      48'h00_00_1C_22_41_00, 48'h00_14_08_3E_08_14, 48'h00_08_08_3E_08_08,
      48'h00_00_00_30_50_00, 48'h00_08_08_08_08_08, 48'h00_00_00_60_60_00,
      48'h00_02_04_08_10_20, 48'h00_3E_45_49_51_3E, 48'h00_00_40_7F_42_00,
      48'h00_46_49_51_61_42, 48'h00_31_4B_45_41_21, 48'h00_10_7F_12_14_18,
      48'h00_39_45_45_45_27, 48'h00_30_49_49_4A_3C, 48'h00_03_05_09_71_01,
      48'h00_36_49_49_49_36, 48'h00_1E_29_49_49_06, 48'h00_7E_11_11_11_7E,
      48'h00_36_49_49_49_7F, 48'h00_22_41_41_41_3E, 48'h00_1C_22_41_41_7F,
      48'h00_41_49_49_49_7F, 48'h00_01_09_09_09_7F, 48'h00_7A_49_49_41_3E,
      48'h00_7F_08_08_08_7F, 48'h00_00_41_7F_41_00, 48'h00_01_3F_41_40_20,
      48'h00_41_22_14_08_7F, 48'h00_40_40_40_40_7F, 48'h00_7F_02_0C_02_7F,
      48'h00_7F_10_08_04_7F, 48'h00_3E_41_41_41_3E, 48'h00_06_09_09_09_7F,
      48'h00_5E_21_51_41_3E, 48'h00_46_29_19_09_7F, 48'h00_31_49_49_49_46,
      48'h00_01_01_7F_01_01, 48'h00_3F_40_40_40_3F, 48'h00_1F_20_40_20_1F,
      48'h00_7F_20_18_20_7F, 48'h00_63_14_08_14_63, 48'h00_07_08_70_08_07,
      48'h00_43_45_49_51_61
   };

   // character byte to font entry; unknown codes draw a space
   function automatic logic [5:0] glyph_index(input logic [7:0] code);
      logic [5:0] idx;
      idx = 6'd0;
      if (code >= 8'h20 && code <= 8'h2F) begin
         idx = 6'(code - 8'h20);
      end else if (code >= 8'h30 && code <= 8'h39) begin
         idx = GLYPH_DIGIT_BASE + 6'(code - 8'h30);
      end else if (code >= 8'h41 && code <= 8'h5A) begin
         idx = GLYPH_ALPHA_BASE + 6'(code - 8'h41);
      end else if (code >= 8'h61 && code <= 8'h7A) begin
         idx = GLYPH_ALPHA_BASE + 6'(code - 8'h61);
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mfgp_frame_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfgp_frame_ram
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mfgp_frame_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: hw/rtl/mfgp_byte_plan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfgp_byte_plan
// Address, bit mask and bit data for one store byte of the current command.
// ----------------------------------------------------------------------------
module mfgp_byte_plan #(
   parameter int DISPLAY_WIDTH  = 128,
   parameter int DISPLAY_HEIGHT = 64,
   parameter int ADDR_W         = 10
) (
   input  wire mfgp_pkg::cmd_type       cmd,
   input  wire logic [2:0]              col,
   input  wire logic                    half,
   output logic      [ADDR_W-1:0]       addr,
   output logic                         in_range,
   output mfgp_pkg::byte_plan_type      plan
);

   localparam int         PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
   localparam int         FULL_PAGES = DISPLAY_HEIGHT / 8;
   localparam logic [7:0] LAST_MASK  = 8'((1 << (DISPLAY_HEIGHT % 8)) - 1);

   logic [7:0]  xs;
   logic [7:0]  page;
   logic [2:0]  sh;
   logic [7:0]  glyph_col;
   logic [15:0] mask_wide;
   logic [15:0] data_wide;
   logic [7:0]  raw_mask;
   logic [7:0]  raw_data;
   logic [7:0]  height_mask;

   always_comb begin
      sh        = cmd.pos_y[2:0];
      glyph_col = mfgp_pkg::GLYPH_ROM[cmd.glyph][{col, 3'b000} +: 8];
      mask_wide = 16'h00FF << sh;
      data_wide = {8'h00, glyph_col} << sh;
      xs        = cmd.pos_x;
      unique case (cmd.op)
         mfgp_pkg::OP_SET_PIXEL: begin
            page     = {3'b000, cmd.pos_y[7:3]};
            raw_mask = 8'h01 << sh;
            raw_data = {8{cmd.pixel_on}};
         end
         mfgp_pkg::OP_DRAW_GLYPH: begin
            // glyph column spans page A (upper part) and page A+1 (lower part)
            xs       = cmd.pos_x + {5'b00000, col};
            page     = {3'b000, cmd.pos_y[7:3] + {4'b0000, half}};
            raw_mask = half ? mask_wide[15:8] : mask_wide[7:0];
            raw_data = half ? data_wide[15:8] : data_wide[7:0];
         end
         default: begin
            page     = cmd.pos_y;
            raw_mask = 8'h00;
            raw_data = 8'h00;
         end
      endcase

      in_range = (int'(page) < PAGE_COUNT) && (int'(xs) < DISPLAY_WIDTH);

      // rows below the display height in a partial last page are dropped
      priority if (int'(page) < FULL_PAGES) begin
         height_mask = 8'hFF;
      end else if (int'(page) == FULL_PAGES) begin
         height_mask = LAST_MASK;
      end else begin
         height_mask = 8'h00;
      end

      addr      = ADDR_W'(int'(page) * DISPLAY_WIDTH + int'(xs));
      plan.mask = raw_mask & height_mask & {8{in_range}};
      plan.data = raw_data;
   end

endmodule
`default_nettype wire

// File: hw/rtl/mono_framebuffer_glyph_plotter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mono_framebuffer_glyph_plotter_top
// Page-organized monochrome frame store with pixel plot, 6x8 glyph draw,
// clear and byte read-back.
// ----------------------------------------------------------------------------
// Use:
//   req_* carries one command word (set pixel, draw glyph, clear, read byte),
//   taken when req_valid and req_ready are both high. Only read byte produces
//   a word on rsp_* (rsp_read_byte); the other commands produce none.
// Sequence (one command at a time, req_ready low while busy):
//   set pixel  : store read, then merged write
//   draw glyph : 6 columns x 2 pages, one read-modify-write each
//   read byte  : store read, then the output register; waits while rsp is stalled
//   clear      : one byte zeroed per cycle through the store write port, over
//                all PAGE_COUNT*DISPLAY_WIDTH bytes (1024 by default)
//   Pixel and glyph byte updates share one read-modify-write path: the store
//   read port, the shared merge, then the store write port.
// Reset: synchronous, active high; afterwards the block runs the same clearing
//   pass as the clear command before req_ready rises.
// Stall: the result sits in an output register; a new command is taken while
//   it waits, and a following read holds in its last step until rsp frees.
// ----------------------------------------------------------------------------
module mono_framebuffer_glyph_plotter_top #(
   parameter int DISPLAY_WIDTH  = mfgp_pkg::DISPLAY_WIDTH_DEF,
   parameter int DISPLAY_HEIGHT = mfgp_pkg::DISPLAY_HEIGHT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [7:0] req_pos_x,
   input  wire logic [7:0] req_pos_y,
   input  wire logic       req_pixel_on,
   input  wire logic [7:0] req_char_code,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [7:0] rsp_read_byte
);

   localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE_SIZE = PAGE_COUNT * DISPLAY_WIDTH;
   localparam int ADDR_W     = $clog2(STORE_SIZE);

   // sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SWEEP   = 3'd1;
   localparam logic [2:0] ST_FETCH   = 3'd2;
   localparam logic [2:0] ST_WRITE   = 3'd3;
   localparam logic [2:0] ST_DELIVER = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       sweep_ff, sweep_in;
   logic [2:0]              col_ff, col_in;
   logic                    half_ff, half_in;
   mfgp_pkg::cmd_type       cmd_ff, cmd_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;

   logic [ADDR_W-1:0]       plan_addr;
   logic                    plan_in_range;
   mfgp_pkg::byte_plan_type plan;

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [7:0]              ram_wr_data;
   logic [7:0]              ram_rd_data;
   logic [7:0]              merged;

   mfgp_byte_plan #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
      .ADDR_W         (ADDR_W)
   ) u_plan (
      .cmd      (cmd_ff),
      .col      (col_ff),
      .half     (half_ff),
      .addr     (plan_addr),
      .in_range (plan_in_range),
      .plan     (plan)
   );

   mfgp_frame_ram #(
      .DEPTH  (STORE_SIZE),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_addr    (plan_addr),
      .rd_data_ff (ram_rd_data)
   );

   // shared merge: touched bits take the new value, others keep the store
   assign merged = (ram_rd_data & ~plan.mask) | (plan.data & plan.mask);

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      col_in       = col_ff;
      half_in      = half_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = plan_addr;
      ram_wr_data  = merged;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in.op       = req_operation;
               cmd_in.pos_x    = req_pos_x;
               cmd_in.pos_y    = req_pos_y;
               cmd_in.pixel_on = req_pixel_on;
               cmd_in.glyph    = mfgp_pkg::glyph_index(req_char_code);
               col_in          = 3'd0;
               half_in         = 1'b0;
               sweep_in        = '0;
               state_in        = (req_operation == mfgp_pkg::OP_CLEAR) ? ST_SWEEP : ST_FETCH;
            end
         end
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = 8'h00;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_W'(STORE_SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            // store read issued at plan_addr; data arrives next cycle
            state_in = (cmd_ff.op == mfgp_pkg::OP_READ_BYTE) ? ST_DELIVER : ST_WRITE;
         end
         ST_WRITE: begin
            ram_wr_en = (plan.mask != 8'h00);
            state_in  = ST_IDLE;
            if (cmd_ff.op == mfgp_pkg::OP_DRAW_GLYPH) begin
               if (!half_ff) begin
                  half_in  = 1'b1;
                  state_in = ST_FETCH;
               end else if (col_ff != mfgp_pkg::GLYPH_LAST_COL) begin
                  half_in  = 1'b0;
                  col_in   = col_ff + 3'd1;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = plan_in_range ? ram_rd_data : 8'h00;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      half_ff     <= half_in;
      cmd_ff      <= cmd_in;
      rsp_byte_ff <= rsp_byte_in;
   end

endmodule
`default_nettype wire
